@@ hw/rtl/mpmp_pkg.sv @@
`timescale 1ns / 1ps

package mpmp_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
  localparam int ADDR_W    = $clog2(MAT_DEPTH);
  localparam int DATA_W    = 60;

  localparam logic [DATA_W-1:0] INF_MARK = 60'd1000000000000000000;
  localparam logic [6:0]        NODE_COUNT_RST  = 7'd64;
  localparam logic [62:0]       PATH_LENGTH_RST = 63'd1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_NODE_COUNT  = 1'b0,
    REG_PATH_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  source_node;
    logic [5:0]  dest_node;
    logic [31:0] edge_weight;
  } in_t;

  typedef struct packed {
    logic        reachable;
    logic [59:0] distance;
  } out_t;

  // row-major entry address of a matrix element
  function automatic logic [ADDR_W-1:0] mat_addr(input int row, input int col);
    return ADDR_W'(row * MAX_NODES + col);
  endfunction

endpackage

@@ hw/rtl/mpmp_ram.sv @@
`timescale 1ns / 1ps

module mpmp_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/min_plus_matrix_power_path_top.sv @@
`timescale 1ns / 1ps

// channel   | ports                          | handshake
// request   | start, busy, request           | taken when start && !busy
// result    | done, result                   | one-cycle strobe, no back-pressure
// config    | wr_en, wr_index, wr_data       | written when wr_en high
//
// add edge reads, compares and writes back one store entry
// clear writes all MAX_NODES^2 entries, one entry written per cycle
// run does at most 2b - 1 matrix multiplies over the n nodes in use, b bits in
// path_length; one product term per cycle
// reset starts the same clearing pass, busy stays high meanwhile
// results cannot be stalled; done pulses once per run request

module min_plus_matrix_power_path_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  mpmp_pkg::in_t  request,
  output logic           done,
  output mpmp_pkg::out_t result,
  input  logic           wr_en,
  input  logic           wr_index,
  input  logic [62:0]    wr_data
);

  import mpmp_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_ADD_RD  = 11'b000_0000_0100,
    S_ADD_WR  = 11'b000_0000_1000,
    S_INIT    = 11'b000_0001_0000,
    S_DECIDE  = 11'b000_0010_0000,
    S_MUL     = 11'b000_0100_0000,
    S_DRAIN   = 11'b000_1000_0000,
    S_COPY    = 11'b001_0000_0000,
    S_FIN_RD  = 11'b010_0000_0000,
    S_FIN_OUT = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [6:0]  node_count;
  logic [62:0] path_length;
  logic [62:0] exp_left;
  logic        phase;
  logic        mul_acc;
  logic [NODE_W-1:0] n_last, i_cnt, j_cnt, p_cnt;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] ed_addr;
  logic [31:0]       ed_w;
  logic              ed_ok;

  logic              cp_vld, cp_from_adj;
  logic [ADDR_W-1:0] cp_addr;

  logic              s1_vld, s1_first, s1_last;
  logic [ADDR_W-1:0] s1_addr;
  logic              s2_vld, s2_first, s2_last;
  logic [ADDR_W-1:0] s2_addr;
  logic [DATA_W-1:0] s2_sum, best;

  logic              adj_we;
  logic [ADDR_W-1:0] adj_waddr, adj_raddr;
  logic [DATA_W-1:0] adj_wdata, adj_rdata;
  logic              p_we;
  logic [DATA_W-1:0] p_wdata, pa_rdata, pb_rdata;
  logic              acc_we;
  logic [ADDR_W-1:0] acc_waddr, acc_raddr;
  logic [DATA_W-1:0] acc_wdata, acc_rdata;
  logic [DATA_W-1:0] scr_rdata;

  logic [ADDR_W-1:0] a_addr, b_addr, ij_addr;
  logic              i_last, j_last, p_last;
  logic [DATA_W-1:0] xa, yb, sat_sum, cand;
  logic [DATA_W:0]   sum;
  logic [NODE_W-1:0] n_last_next;

  assign a_addr  = mat_addr(int'(i_cnt), int'(p_cnt));
  assign b_addr  = mat_addr(int'(p_cnt), int'(j_cnt));
  assign ij_addr = mat_addr(int'(i_cnt), int'(j_cnt));
  assign i_last  = (i_cnt == n_last);
  assign j_last  = (j_cnt == n_last);
  assign p_last  = (p_cnt == n_last);
  assign busy    = (state != S_IDLE);

  // node count out of range folds onto 1..MAX_NODES
  always_comb begin
    if (node_count == 7'd0) begin
      n_last_next = '0;
    end else if (32'(node_count) > MAX_NODES) begin
      n_last_next = NODE_W'(MAX_NODES - 1);
    end else begin
      n_last_next = NODE_W'(node_count - 7'd1);
    end
  end

  // adjacency store port
  assign adj_raddr = (state == S_INIT) ? ij_addr : ed_addr;
  always_comb begin
    if (state == S_CLEAR) begin
      adj_we    = 1'b1;
      adj_waddr = clr_addr;
      adj_wdata = INF_MARK;
    end else begin
      adj_we    = (state == S_ADD_WR) && ed_ok && (DATA_W'(ed_w) < adj_rdata);
      adj_waddr = ed_addr;
      adj_wdata = DATA_W'(ed_w);
    end
  end

  // power matrix kept twice so a squaring can read two entries a cycle
  assign p_we    = cp_vld && (cp_from_adj || !mul_acc);
  assign p_wdata = cp_from_adj ? adj_rdata : scr_rdata;

  always_comb begin
    if (state == S_INIT) begin
      acc_we    = 1'b1;
      acc_waddr = ij_addr;
      acc_wdata = (i_cnt == j_cnt) ? '0 : INF_MARK;
    end else begin
      acc_we    = cp_vld && !cp_from_adj && mul_acc;
      acc_waddr = cp_addr;
      acc_wdata = scr_rdata;
    end
  end
  assign acc_raddr = (state == S_FIN_RD) ? mat_addr(0, int'(n_last)) : a_addr;

  // product term with saturation at the infinity marker
  assign xa  = mul_acc ? acc_rdata : pa_rdata;
  assign yb  = pb_rdata;
  assign sum = {1'b0, xa} + {1'b0, yb};
  assign sat_sum = (xa >= INF_MARK || yb >= INF_MARK || sum >= {1'b0, INF_MARK})
                   ? INF_MARK : sum[DATA_W-1:0];
  assign cand = (s2_first || s2_sum < best) ? s2_sum : best;

  mpmp_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  mpmp_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_pow_a (
    .clk(clk), .we(p_we), .waddr(cp_addr), .wdata(p_wdata),
    .raddr(a_addr), .rdata(pa_rdata)
  );

  mpmp_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_pow_b (
    .clk(clk), .we(p_we), .waddr(cp_addr), .wdata(p_wdata),
    .raddr(b_addr), .rdata(pb_rdata)
  );

  mpmp_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  mpmp_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_scr (
    .clk(clk), .we(s2_vld && s2_last), .waddr(s2_addr), .wdata(cand),
    .raddr(ij_addr), .rdata(scr_rdata)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    s1_first <= (p_cnt == '0);
    s1_last  <= p_last;
    s1_addr  <= ij_addr;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_addr  <= s1_addr;
    s2_sum   <= sat_sum;
    cp_addr  <= ij_addr;
    if (s2_vld) begin
      best <= cand;
    end
    if (state == S_FIN_OUT) begin
      result.reachable <= (acc_rdata < INF_MARK);
      result.distance  <= (acc_rdata < INF_MARK) ? acc_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      exp_left    <= '0;
      phase       <= 1'b0;
      mul_acc     <= 1'b0;
      s1_vld      <= 1'b0;
      s2_vld      <= 1'b0;
      cp_vld      <= 1'b0;
      cp_from_adj <= 1'b0;
      done        <= 1'b0;
      node_count  <= NODE_COUNT_RST;
      path_length <= PATH_LENGTH_RST;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_NODE_COUNT:  node_count  <= wr_data[6:0];
          REG_PATH_LENGTH: path_length <= wr_data;
          default: ;
        endcase
      end
      done   <= 1'b0;
      s1_vld <= 1'b0;
      cp_vld <= 1'b0;
      s2_vld <= s1_vld;

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAT_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (request.command)
              CMD_ADD: begin
                ed_addr <= mat_addr(int'(request.source_node), int'(request.dest_node));
                ed_w    <= request.edge_weight;
                ed_ok   <= (32'(request.source_node) < MAX_NODES) &&
                           (32'(request.dest_node) < MAX_NODES);
                state   <= S_ADD_RD;
              end
              CMD_RUN: begin
                n_last   <= n_last_next;
                exp_left <= path_length;
                phase    <= 1'b0;
                i_cnt    <= '0;
                j_cnt    <= '0;
                state    <= S_INIT;
              end
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: state <= S_IDLE;
        S_INIT: begin
          cp_vld      <= 1'b1;
          cp_from_adj <= 1'b1;
          j_cnt <= j_last ? '0 : j_cnt + 1'b1;
          if (j_last) begin
            i_cnt <= i_cnt + 1'b1;
            if (i_last) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          i_cnt <= '0;
          j_cnt <= '0;
          p_cnt <= '0;
          if (!phase) begin
            if (exp_left == '0) begin
              state <= S_FIN_RD;
            end else begin
              phase <= 1'b1;
              if (exp_left[0]) begin
                mul_acc <= 1'b1;
                state   <= S_MUL;
              end
            end
          end else begin
            exp_left <= exp_left >> 1;
            phase    <= 1'b0;
            if (exp_left[62:1] != '0) begin
              mul_acc <= 1'b0;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          s1_vld <= 1'b1;
          p_cnt  <= p_last ? '0 : p_cnt + 1'b1;
          if (p_last) begin
            j_cnt <= j_last ? '0 : j_cnt + 1'b1;
            if (j_last) begin
              i_cnt <= i_cnt + 1'b1;
              if (i_last) begin
                state <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          i_cnt <= '0;
          j_cnt <= '0;
          if (!s1_vld && !s2_vld) begin
            state <= S_COPY;
          end
        end
        S_COPY: begin
          cp_vld      <= 1'b1;
          cp_from_adj <= 1'b0;
          j_cnt <= j_last ? '0 : j_cnt + 1'b1;
          if (j_last) begin
            i_cnt <= i_cnt + 1'b1;
            if (i_last) begin
              state <= S_DECIDE;
            end
          end
        end
        S_FIN_RD: state <= S_FIN_OUT;
        S_FIN_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_FIN_OUT)
    else $error("result strobe without a finished run");

  a_exp_spent: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> exp_left == '0)
    else $error("exponent left over at idle");

  a_mul_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> (i_cnt <= n_last && j_cnt <= n_last && p_cnt <= n_last))
    else $error("product index beyond nodes in use");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.reachable |-> result.distance == '0)
    else $error("unreachable result with nonzero distance");

  a_scr_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> !s2_vld && !s1_vld)
    else $error("product pipeline still busy during copy");

endmodule
